// ===== rtl/mkqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the multi-key quickselect block.
// Used by mkqs_ctrl, mkqs_datapath and multi_key_quickselect; no dependencies.

package mkqs_pkg;

   localparam int IDX_BITS       = 10;
   localparam int FIELD_BITS     = 32;
   localparam int OP_BITS        = 2;
   localparam int DEF_POINTS     = 1024;
   localparam int DEF_AXES       = 2;
   localparam int DEF_VALUE_BITS = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE  = 2'd0,
      OP_SELECT = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ROUND,
      ST_PIV_MID,
      ST_PIV_SAVE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SWAP_RD,
      ST_SWAP_WR_I,
      ST_SWAP_WR_M,
      ST_END_WR_LO,
      ST_END_WR_M,
      ST_DONE_OK,
      ST_DONE_ERR,
      ST_DONE_MEM
   } state_type;

   typedef enum logic [2:0] {
      ADDR_IDX,
      ADDR_LO,
      ADDR_MID,
      ADDR_I,
      ADDR_M,
      ADDR_RANK
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_REQ,
      WD_TMP,
      WD_RD,
      WD_PIVOT
   } wdata_sel_type;

   typedef struct packed {
      logic          latch_req;
      logic          rd_en;
      logic          wr_en;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      logic          sel_init;
      logic          save_tmp;
      logic          save_pivot;
      logic          scan_init;
      logic          m_inc;
      logic          i_inc;
      logic          round_update;
      logic          out_load;
      logic          out_mem;
      logic          out_err;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   idx_ok;
      logic   range_ok;
      logic   lo_lt_hi;
      logic   i_gt_hi;
      logic   key_less;
      logic   m_eq_i;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/multi_key_quickselect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Point store with in-place Lomuto quickselect; one request word in service at a time.
// Write and read: the decode state accesses the store, the done state loads the result;
// no new word is taken until then. Select: per round, pivot reads and write, a scan
// with a swap per smaller key (no writes in place), end writes; all on one store port.
// A new word is accepted once the previous result is loaded, even if it is still stalled.
// Reset clears the sequencer and the result valid; the store is not cleared.

module multi_key_quickselect #(
   parameter int POINTS     = mkqs_pkg::DEF_POINTS,
   parameter int AXES       = mkqs_pkg::DEF_AXES,
   parameter int VALUE_BITS = mkqs_pkg::DEF_VALUE_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic        [mkqs_pkg::OP_BITS-1:0]    req_operation,
   input  wire logic        [mkqs_pkg::IDX_BITS-1:0]   req_index,
   input  wire logic signed [mkqs_pkg::FIELD_BITS-1:0] req_coord_x,
   input  wire logic signed [mkqs_pkg::FIELD_BITS-1:0] req_coord_y,
   input  wire logic signed [mkqs_pkg::FIELD_BITS-1:0] req_width_x,
   input  wire logic signed [mkqs_pkg::FIELD_BITS-1:0] req_width_y,
   input  wire logic        [mkqs_pkg::IDX_BITS-1:0]   req_range_low,
   input  wire logic        [mkqs_pkg::IDX_BITS-1:0]   req_range_high,
   input  wire logic        [mkqs_pkg::IDX_BITS-1:0]   req_target_rank,
   input  wire logic                                   req_key_axis,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed      [mkqs_pkg::FIELD_BITS-1:0] rsp_out_x,
   output logic signed      [mkqs_pkg::FIELD_BITS-1:0] rsp_out_y,
   output logic signed      [mkqs_pkg::FIELD_BITS-1:0] rsp_out_width_x,
   output logic signed      [mkqs_pkg::FIELD_BITS-1:0] rsp_out_width_y,
   output logic                                        rsp_status
);
   import mkqs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mkqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   mkqs_datapath #(
      .POINTS     (POINTS),
      .AXES       (AXES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_index       (req_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_width_x     (req_width_x),
      .req_width_y     (req_width_y),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .req_target_rank (req_target_rank),
      .req_key_axis    (req_key_axis),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_width_x (rsp_out_width_x),
      .rsp_out_width_y (rsp_out_width_y),
      .rsp_status      (rsp_status)
   );

   // store is single ported
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("store read and write in the same cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word accepted while one is in service");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register loaded while holding a stalled word");

endmodule

`default_nettype wire

// ===== rtl/mkqs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequencer for writes, reads and the Lomuto quickselect rounds.
// Depends on mkqs_pkg; drives mkqs_datapath through cmd_type / stat_type.

module mkqs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output mkqs_pkg::cmd_type       cmd,
   input  wire mkqs_pkg::stat_type stat
);
   import mkqs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      done_go;

   assign done_go   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (stat.op)
               OP_WRITE:  state_in = stat.idx_ok ? ST_DONE_OK : ST_DONE_ERR;
               OP_READ:   state_in = stat.idx_ok ? ST_DONE_MEM : ST_DONE_ERR;
               OP_SELECT: state_in = stat.range_ok ? ST_ROUND : ST_DONE_ERR;
               default:   state_in = ST_DONE_ERR;
            endcase
         end
         ST_ROUND:     state_in = stat.lo_lt_hi ? ST_PIV_MID : ST_DONE_MEM;
         ST_PIV_MID:   state_in = ST_PIV_SAVE;
         ST_PIV_SAVE:  state_in = ST_SCAN_RD;
         ST_SCAN_RD:   state_in = stat.i_gt_hi ? ST_END_WR_LO : ST_SCAN_CMP;
         ST_SCAN_CMP:  state_in = stat.key_less ? ST_SWAP_RD : ST_SCAN_RD;
         ST_SWAP_RD:   state_in = stat.m_eq_i ? ST_SCAN_RD : ST_SWAP_WR_I;
         ST_SWAP_WR_I: state_in = ST_SWAP_WR_M;
         ST_SWAP_WR_M: state_in = ST_SCAN_RD;
         ST_END_WR_LO: state_in = ST_END_WR_M;
         ST_END_WR_M:  state_in = ST_ROUND;
         ST_DONE_OK, ST_DONE_ERR, ST_DONE_MEM: begin
            if (done_go) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch_req = req_valid;
         end
         ST_DECODE: begin
            cmd.addr_sel  = ADDR_IDX;
            cmd.wdata_sel = WD_REQ;
            cmd.wr_en     = (stat.op == OP_WRITE) && stat.idx_ok;
            cmd.rd_en     = (stat.op == OP_READ) && stat.idx_ok;
            cmd.sel_init  = (stat.op == OP_SELECT) && stat.range_ok;
         end
         ST_ROUND: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = stat.lo_lt_hi ? ADDR_LO : ADDR_RANK;
         end
         ST_PIV_MID: begin
            cmd.save_tmp = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_MID;
         end
         ST_PIV_SAVE: begin
            // old low element moves to the middle slot; pivot stays in a register
            cmd.save_pivot = 1'b1;
            cmd.wr_en      = 1'b1;
            cmd.addr_sel   = ADDR_MID;
            cmd.wdata_sel  = WD_TMP;
            cmd.scan_init  = 1'b1;
         end
         ST_SCAN_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = stat.i_gt_hi ? ADDR_M : ADDR_I;
         end
         ST_SCAN_CMP: begin
            cmd.save_tmp = 1'b1;
            cmd.m_inc    = stat.key_less;
            cmd.i_inc    = !stat.key_less;
         end
         ST_SWAP_RD: begin
            cmd.i_inc    = stat.m_eq_i;
            cmd.rd_en    = !stat.m_eq_i;
            cmd.addr_sel = ADDR_M;
         end
         ST_SWAP_WR_I: begin
            cmd.wr_en     = 1'b1;
            cmd.addr_sel  = ADDR_I;
            cmd.wdata_sel = WD_RD;
         end
         ST_SWAP_WR_M: begin
            cmd.wr_en     = 1'b1;
            cmd.addr_sel  = ADDR_M;
            cmd.wdata_sel = WD_TMP;
            cmd.i_inc     = 1'b1;
         end
         ST_END_WR_LO: begin
            cmd.wr_en     = 1'b1;
            cmd.addr_sel  = ADDR_LO;
            cmd.wdata_sel = WD_RD;
         end
         ST_END_WR_M: begin
            cmd.wr_en        = 1'b1;
            cmd.addr_sel     = ADDR_M;
            cmd.wdata_sel    = WD_PIVOT;
            cmd.round_update = 1'b1;
         end
         ST_DONE_OK: begin
            cmd.out_load = done_go;
         end
         ST_DONE_ERR: begin
            cmd.out_load = done_go;
            cmd.out_err  = 1'b1;
         end
         ST_DONE_MEM: begin
            cmd.out_load = done_go;
            cmd.out_mem  = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mkqs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Point store, index registers, pivot/temp registers and result register.
// Depends on mkqs_pkg; commanded by mkqs_ctrl.

module mkqs_datapath #(
   parameter int POINTS     = mkqs_pkg::DEF_POINTS,
   parameter int AXES       = mkqs_pkg::DEF_AXES,
   parameter int VALUE_BITS = mkqs_pkg::DEF_VALUE_BITS
) (
   input  wire logic                                      clock,
   input  wire mkqs_pkg::cmd_type                         cmd,
   output mkqs_pkg::stat_type                             stat,
   input  wire logic        [mkqs_pkg::OP_BITS-1:0]       req_operation,
   input  wire logic        [mkqs_pkg::IDX_BITS-1:0]      req_index,
   input  wire logic signed [mkqs_pkg::FIELD_BITS-1:0]    req_coord_x,
   input  wire logic signed [mkqs_pkg::FIELD_BITS-1:0]    req_coord_y,
   input  wire logic signed [mkqs_pkg::FIELD_BITS-1:0]    req_width_x,
   input  wire logic signed [mkqs_pkg::FIELD_BITS-1:0]    req_width_y,
   input  wire logic        [mkqs_pkg::IDX_BITS-1:0]      req_range_low,
   input  wire logic        [mkqs_pkg::IDX_BITS-1:0]      req_range_high,
   input  wire logic        [mkqs_pkg::IDX_BITS-1:0]      req_target_rank,
   input  wire logic                                      req_key_axis,
   output logic signed      [mkqs_pkg::FIELD_BITS-1:0]    rsp_out_x,
   output logic signed      [mkqs_pkg::FIELD_BITS-1:0]    rsp_out_y,
   output logic signed      [mkqs_pkg::FIELD_BITS-1:0]    rsp_out_width_x,
   output logic signed      [mkqs_pkg::FIELD_BITS-1:0]    rsp_out_width_y,
   output logic                                           rsp_status
);
   import mkqs_pkg::*;

   localparam int ADDR_BITS = $clog2(POINTS);
   localparam int REC_BITS  = 2 * AXES * VALUE_BITS;

   // request words
   op_type                   op_ff;
   logic [IDX_BITS-1:0]      idx_ff;
   logic signed [FIELD_BITS-1:0] coord_x_ff, coord_y_ff, width_x_ff, width_y_ff;
   logic [IDX_BITS-1:0]      range_low_ff, range_high_ff, rank_ff;
   logic                     key_axis_ff;

   // select bookkeeping
   logic [IDX_BITS-1:0]      lo_ff, lo_in, hi_ff, hi_in, m_ff, m_in;
   logic [IDX_BITS:0]        i_ff, i_in;
   logic [IDX_BITS:0]        mid_sum;
   logic [IDX_BITS-1:0]      mid;

   // store: one record per point, positions then bandwidths
   logic [REC_BITS-1:0]      mem [POINTS];
   logic [REC_BITS-1:0]      rd_ff, tmp_ff, pivot_ff, req_rec, wr_data;
   logic [IDX_BITS-1:0]      addr_idx;
   logic [ADDR_BITS-1:0]     mem_addr;

   logic signed [VALUE_BITS-1:0] key_rd, key_pivot;
   logic signed [FIELD_BITS-1:0] rd_x, rd_y, rd_wx, rd_wy;

   logic signed [FIELD_BITS-1:0] out_x_ff, out_y_ff, out_wx_ff, out_wy_ff;
   logic                         status_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff         <= op_type'(req_operation);
         idx_ff        <= req_index;
         coord_x_ff    <= req_coord_x;
         coord_y_ff    <= req_coord_y;
         width_x_ff    <= req_width_x;
         width_y_ff    <= req_width_y;
         range_low_ff  <= req_range_low;
         range_high_ff <= req_range_high;
         rank_ff       <= req_target_rank;
         key_axis_ff   <= req_key_axis;
      end
   end

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_BITS:1];

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      m_in  = m_ff;
      i_in  = i_ff;
      if (cmd.sel_init) begin
         lo_in = range_low_ff;
         hi_in = range_high_ff;
      end
      if (cmd.round_update) begin
         if (m_ff < rank_ff) begin
            lo_in = m_ff + 1'b1;
         end else if (m_ff > rank_ff) begin
            hi_in = m_ff - 1'b1;
         end else begin
            lo_in = m_ff;
            hi_in = m_ff;
         end
      end
      if (cmd.scan_init) begin
         m_in = lo_ff;
         i_in = {1'b0, lo_ff} + 1'b1;
      end
      if (cmd.m_inc) m_in = m_ff + 1'b1;
      if (cmd.i_inc) i_in = i_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      m_ff  <= m_in;
      i_ff  <= i_in;
      if (cmd.save_tmp) tmp_ff <= rd_ff;
      if (cmd.save_pivot) pivot_ff <= rd_ff;
   end

   always_comb begin
      case (cmd.addr_sel)
         ADDR_IDX:  addr_idx = idx_ff;
         ADDR_LO:   addr_idx = lo_ff;
         ADDR_MID:  addr_idx = mid;
         ADDR_I:    addr_idx = i_ff[IDX_BITS-1:0];
         ADDR_M:    addr_idx = m_ff;
         ADDR_RANK: addr_idx = rank_ff;
         default:   addr_idx = idx_ff;
      endcase
   end

   assign mem_addr = ADDR_BITS'(addr_idx);

   always_comb begin
      case (cmd.wdata_sel)
         WD_REQ:   wr_data = req_rec;
         WD_TMP:   wr_data = tmp_ff;
         WD_RD:    wr_data = rd_ff;
         WD_PIVOT: wr_data = pivot_ff;
         default:  wr_data = req_rec;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[mem_addr] <= wr_data;
      if (cmd.rd_en) rd_ff <= mem[mem_addr];
   end

   for (genvar a = 0; a < AXES; a++) begin : g_req
      if (a == 0) begin : g_ax0
         assign req_rec[a*VALUE_BITS +: VALUE_BITS]        = VALUE_BITS'(coord_x_ff);
         assign req_rec[(AXES+a)*VALUE_BITS +: VALUE_BITS] = VALUE_BITS'(width_x_ff);
      end else if (a == 1) begin : g_ax1
         assign req_rec[a*VALUE_BITS +: VALUE_BITS]        = VALUE_BITS'(coord_y_ff);
         assign req_rec[(AXES+a)*VALUE_BITS +: VALUE_BITS] = VALUE_BITS'(width_y_ff);
      end else begin : g_axn
         assign req_rec[a*VALUE_BITS +: VALUE_BITS]        = '0;
         assign req_rec[(AXES+a)*VALUE_BITS +: VALUE_BITS] = '0;
      end
   end

   assign rd_x  = FIELD_BITS'($signed(rd_ff[0 +: VALUE_BITS]));
   assign rd_wx = FIELD_BITS'($signed(rd_ff[AXES*VALUE_BITS +: VALUE_BITS]));

   if (AXES > 1) begin : g_two
      assign rd_y      = FIELD_BITS'($signed(rd_ff[VALUE_BITS +: VALUE_BITS]));
      assign rd_wy     = FIELD_BITS'($signed(rd_ff[(AXES+1)*VALUE_BITS +: VALUE_BITS]));
      assign key_rd    = key_axis_ff ? $signed(rd_ff[VALUE_BITS +: VALUE_BITS])
                                     : $signed(rd_ff[0 +: VALUE_BITS]);
      assign key_pivot = key_axis_ff ? $signed(pivot_ff[VALUE_BITS +: VALUE_BITS])
                                     : $signed(pivot_ff[0 +: VALUE_BITS]);
   end else begin : g_one
      assign rd_y      = '0;
      assign rd_wy     = '0;
      assign key_rd    = $signed(rd_ff[0 +: VALUE_BITS]);
      assign key_pivot = $signed(pivot_ff[0 +: VALUE_BITS]);
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_x_ff  <= cmd.out_mem ? rd_x  : '0;
         out_y_ff  <= cmd.out_mem ? rd_y  : '0;
         out_wx_ff <= cmd.out_mem ? rd_wx : '0;
         out_wy_ff <= cmd.out_mem ? rd_wy : '0;
         status_ff <= cmd.out_err;
      end
   end

   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_out_width_x = out_wx_ff;
   assign rsp_out_width_y = out_wy_ff;
   assign rsp_status      = status_ff;

   assign stat.op       = op_ff;
   assign stat.idx_ok   = 32'(idx_ff) < POINTS;
   assign stat.range_ok = (range_low_ff <= range_high_ff)
                       && (32'(range_high_ff) < POINTS)
                       && (rank_ff >= range_low_ff)
                       && (rank_ff <= range_high_ff)
                       && (!key_axis_ff || (AXES > 1));
   assign stat.lo_lt_hi = lo_ff < hi_ff;
   assign stat.i_gt_hi  = i_ff > {1'b0, hi_ff};
   assign stat.key_less = key_rd < key_pivot;
   assign stat.m_eq_i   = {1'b0, m_ff} == i_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_multi_key_quickselect.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_key_quickselect: directed and random write, read
// and select words, checked against an in-bench point store and quickselect predictor.
// Depends on mkqs_pkg and the multi_key_quickselect RTL.

module tb_multi_key_quickselect;
   import mkqs_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 267;
   localparam int DRAIN_AT     = 150;
   localparam int WINDOW_TOP   = 47;
   localparam int HIGH_BASE    = 1008;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [OP_BITS-1:0]         op;
      logic [IDX_BITS-1:0]        index;
      logic signed [FIELD_BITS-1:0] cx, cy, wx, wy;
      logic [IDX_BITS-1:0]        lo, hi, rank;
      logic                       axis;
   } point_req_type;

   typedef struct {
      logic signed [FIELD_BITS-1:0] x, y, wx, wy;
      logic                         status;
   } point_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [OP_BITS-1:0]           req_operation = '0;
   logic [IDX_BITS-1:0]          req_index = '0;
   logic signed [FIELD_BITS-1:0] req_coord_x = '0;
   logic signed [FIELD_BITS-1:0] req_coord_y = '0;
   logic signed [FIELD_BITS-1:0] req_width_x = '0;
   logic signed [FIELD_BITS-1:0] req_width_y = '0;
   logic [IDX_BITS-1:0]          req_range_low = '0;
   logic [IDX_BITS-1:0]          req_range_high = '0;
   logic [IDX_BITS-1:0]          req_target_rank = '0;
   logic                         req_key_axis = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [FIELD_BITS-1:0] rsp_out_x;
   logic signed [FIELD_BITS-1:0] rsp_out_y;
   logic signed [FIELD_BITS-1:0] rsp_out_width_x;
   logic signed [FIELD_BITS-1:0] rsp_out_width_y;
   logic                         rsp_status;

   multi_key_quickselect DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_index       (req_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_width_x     (req_width_x),
      .req_width_y     (req_width_y),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .req_target_rank (req_target_rank),
      .req_key_axis    (req_key_axis),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_width_x (rsp_out_width_x),
      .rsp_out_width_y (rsp_out_width_y),
      .rsp_status      (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   point_req_type pending_words[$];
   point_rsp_type expected_points[$];
   point_req_type cur_word;

   logic signed [FIELD_BITS-1:0] pt_x  [DEF_POINTS];
   logic signed [FIELD_BITS-1:0] pt_y  [DEF_POINTS];
   logic signed [FIELD_BITS-1:0] pt_wx [DEF_POINTS];
   logic signed [FIELD_BITS-1:0] pt_wy [DEF_POINTS];

   int total_words = 1;
   int n_accepted = 0;
   int n_results = 0;
   int n_mismatch = 0;
   int n_errors = 0;
   int n_writes = 0, n_reads = 0, n_selects = 0, n_rejects = 0;

   function automatic int load_phase();
      return (n_accepted * 5) / total_words;
   endfunction

   function automatic void add_word(input point_req_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic void swap_slots(input int a, input int b);
      logic signed [FIELD_BITS-1:0] t;
      t = pt_x[a];  pt_x[a]  = pt_x[b];  pt_x[b]  = t;
      t = pt_y[a];  pt_y[a]  = pt_y[b];  pt_y[b]  = t;
      t = pt_wx[a]; pt_wx[a] = pt_wx[b]; pt_wx[b] = t;
      t = pt_wy[a]; pt_wy[a] = pt_wy[b]; pt_wy[b] = t;
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] key_of(input logic axis, input int i);
      return axis ? pt_y[i] : pt_x[i];
   endfunction

   // Store-copy model; a select runs Lomuto and queues the point left at the rank slot.
   function automatic void predict_response(input point_req_type w);
      point_rsp_type r;
      int lo, hi, rank, mid, m, i;
      r = '{default: '0};
      lo = int'(w.lo);
      hi = int'(w.hi);
      rank = int'(w.rank);
      if (w.op == OP_WRITE) begin
         pt_x[w.index]  = w.cx;
         pt_y[w.index]  = w.cy;
         pt_wx[w.index] = w.wx;
         pt_wy[w.index] = w.wy;
         n_writes++;
      end else if (w.op == OP_READ) begin
         r = '{pt_x[w.index], pt_y[w.index], pt_wx[w.index], pt_wy[w.index], 1'b0};
         n_reads++;
      end else if (w.op == OP_SELECT && lo <= hi && hi < DEF_POINTS && rank >= lo
                   && rank <= hi && int'(w.axis) < DEF_AXES) begin
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            swap_slots(mid, lo);
            m = lo;
            for (i = lo + 1; i <= hi; i++) begin
               if (key_of(w.axis, i) < key_of(w.axis, lo)) begin
                  m++;
                  swap_slots(m, i);
               end
            end
            swap_slots(lo, m);
            if (m <= rank) lo = m + 1;
            if (m >= rank) hi = m - 1;
         end
         r = '{pt_x[rank], pt_y[rank], pt_wx[rank], pt_wy[rank], 1'b0};
         n_selects++;
      end else begin
         r.status = 1'b1;
         n_rejects++;
      end
      expected_points.insert(expected_points.size(), r);
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] rand_value();
      int pick;
      pick = $urandom_range(9);
      if (pick < 2) begin
         case ($urandom_range(4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
         endcase
      end
      if (pick < 5) return $signed(32'($urandom_range(16))) - 32'sd8;
      return $signed($urandom());
   endfunction

   // Every field random; callers override what the operation uses.
   function automatic point_req_type make_word(input logic [OP_BITS-1:0] op);
      point_req_type w;
      w.op    = op;
      w.index = IDX_BITS'($urandom());
      w.cx    = rand_value();
      w.cy    = rand_value();
      w.wx    = rand_value();
      w.wy    = rand_value();
      w.lo    = IDX_BITS'($urandom());
      w.hi    = IDX_BITS'($urandom());
      w.rank  = IDX_BITS'($urandom());
      w.axis  = 1'($urandom());
      return w;
   endfunction

   always @(posedge clock) begin : drive_requests
      logic take;
      int phase;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_response(cur_word);
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            phase = load_phase();
            take = pending_words.size() != 0
                   && !(n_accepted == DRAIN_AT && expected_points.size() != 0);
            if (take && phase == 1) take = $urandom_range(99) >= 67;
            if (take && phase == 3) take = $urandom_range(99) >= 34;
            if (take) begin
               cur_word = pending_words.pop_front();
               req_operation   <= cur_word.op;
               req_index       <= cur_word.index;
               req_coord_x     <= cur_word.cx;
               req_coord_y     <= cur_word.cy;
               req_width_x     <= cur_word.wx;
               req_width_y     <= cur_word.wy;
               req_range_low   <= cur_word.lo;
               req_range_high  <= cur_word.hi;
               req_target_rank <= cur_word.rank;
               req_key_axis    <= cur_word.axis;
            end
            req_valid <= take;
         end
      end
   end

   always @(posedge clock) begin : check_results
      point_rsp_type want;
      int phase;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               n_errors++;
               $display("result %0d arrived with nothing outstanding", n_results);
            end else begin
               want = expected_points.pop_front();
               if (rsp_out_x !== want.x || rsp_out_y !== want.y
                   || rsp_out_width_x !== want.wx || rsp_out_width_y !== want.wy
                   || rsp_status !== want.status) begin
                  n_errors++;
                  n_mismatch++;
                  if (n_mismatch <= MAX_REPORTS) begin
                     $display("result %0d differs: expected x=%0d y=%0d wx=%0d wy=%0d st=%0d",
                              n_results, want.x, want.y, want.wx, want.wy, want.status);
                     $display("   got x=%0d y=%0d wx=%0d wy=%0d st=%0d",
                              rsp_out_x, rsp_out_y, rsp_out_width_x, rsp_out_width_y,
                              rsp_status);
                  end
               end
            end
            n_results++;
         end
         phase = load_phase();
         if (phase == 2)      rsp_stall <= $urandom_range(99) < 67;
         else if (phase == 3) rsp_stall <= $urandom_range(99) < 34;
         else                 rsp_stall <= 1'b0;
      end
   end

   initial begin : stimulus
      logic signed [FIELD_BITS-1:0] corner_vals [8];
      logic written [DEF_POINTS];
      int written_slots[$];
      point_req_type w;
      int j, kind, base, top, lo, hi, len, hole;

      corner_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1,
                      32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5};
      for (j = 0; j < DEF_POINTS; j++) written[j] = 1'b0;

      // directed: corner values with duplicate keys, top slots, reads, selects, rejects
      for (j = 0; j < 8; j++) begin
         w = make_word(OP_WRITE);
         w.index = IDX_BITS'(j);
         w.cx = corner_vals[j];
         w.cy = corner_vals[7 - j];
         w.wx = ~corner_vals[j];
         w.wy = corner_vals[(j + 3) % 8];
         add_word(w);
         written[j] = 1'b1;
         written_slots.insert(written_slots.size(), j);
      end
      for (j = DEF_POINTS - 4; j < DEF_POINTS; j++) begin
         w = make_word(OP_WRITE);
         w.index = IDX_BITS'(j);
         add_word(w);
         written[j] = 1'b1;
         written_slots.insert(written_slots.size(), j);
      end
      w = make_word(OP_READ);   w.index = '0;  add_word(w);
      w = make_word(OP_READ);   w.index = '1;  add_word(w);
      w = make_word(OP_SELECT); w.lo = 3; w.hi = 3; w.rank = 3; w.axis = 0;
      add_word(w);
      w = make_word(OP_SELECT); w.lo = 0; w.hi = 7; w.rank = 0; w.axis = 0;
      add_word(w);
      w = make_word(OP_SELECT); w.lo = 0; w.hi = 7; w.rank = 7; w.axis = 1;
      add_word(w);
      w = make_word(OP_SELECT); w.lo = 0; w.hi = 7; w.rank = 4; w.axis = 0;
      add_word(w);
      w = make_word(OP_SELECT); w.lo = IDX_BITS'(DEF_POINTS - 4);
      w.hi = '1; w.rank = '1; w.axis = 1;
      add_word(w);
      w = make_word(OP_SELECT); w.lo = 9; w.hi = 2; w.rank = 5;
      add_word(w);
      w = make_word(OP_SELECT); w.lo = 4; w.hi = 9; w.rank = 3;
      add_word(w);
      w = make_word(OP_SELECT); w.lo = 0; w.hi = 6; w.rank = 7;
      add_word(w);
      w = make_word(OP_UNUSED);
      add_word(w);

      for (j = 0; j < RANDOM_WORDS; j++) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            w = make_word(OP_WRITE);
            case ($urandom_range(9))
               8:       w.index = IDX_BITS'($urandom_range(DEF_POINTS - 1, HIGH_BASE));
               9:       w.index = IDX_BITS'($urandom_range(DEF_POINTS - 1));
               default: w.index = IDX_BITS'($urandom_range(WINDOW_TOP));
            endcase
         end else if (kind < 55) begin
            w = make_word(OP_READ);
            w.index = IDX_BITS'(written_slots[$urandom_range(written_slots.size() - 1)]);
         end else if (kind < 88) begin
            if ($urandom_range(99) < 85) begin
               base = 0;
               top = WINDOW_TOP;
            end else begin
               base = HIGH_BASE;
               top = DEF_POINTS - 1;
            end
            lo = $urandom_range(top, base);
            len = ($urandom_range(9) == 0) ? $urandom_range(WINDOW_TOP) : $urandom_range(15);
            hi = (lo + len > top) ? top : lo + len;
            hole = -1;
            for (int k = hi; k >= lo; k--)
               if (!written[k]) hole = k;
            if (hole >= 0) begin
               // fill the gap first so the select never reads an unwritten slot
               w = make_word(OP_WRITE);
               w.index = IDX_BITS'(hole);
            end else begin
               w = make_word(OP_SELECT);
               w.lo = IDX_BITS'(lo);
               w.hi = IDX_BITS'(hi);
               w.rank = IDX_BITS'($urandom_range(hi, lo));
            end
         end else if (kind < 97) begin
            w = make_word(OP_SELECT);
            if (w.lo <= w.hi && w.rank >= w.lo && w.rank <= w.hi) begin
               if (w.lo == w.hi) begin
                  w.rank = w.lo ^ IDX_BITS'(1);
               end else begin
                  w.lo = w.lo ^ w.hi;
                  w.hi = w.lo ^ w.hi;
                  w.lo = w.lo ^ w.hi;
               end
            end
         end else begin
            w = make_word(OP_UNUSED);
         end
         if (w.op == OP_WRITE && !written[w.index]) begin
            written[w.index] = 1'b1;
            written_slots.insert(written_slots.size(), int'(w.index));
         end
         add_word(w);
      end
      total_words = pending_words.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_points.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (expected_points.size() != 0) begin
         n_errors++;
         $display("%0d results never arrived", expected_points.size());
      end
      $display("covered %0d words: %0d writes, %0d reads, %0d selects, %0d rejected",
               n_accepted, n_writes, n_reads, n_selects, n_rejects);
      $display("traffic ran free, sender-idle, receiver-stall and mixed, with one drain pause");
      if (n_errors == 0)
         $display("multi_key_quickselect: match");
      else
         $display("multi_key_quickselect: mismatch");
      $finish;
   end

   initial begin : watchdog
      #50_000_000;
      $display("multi_key_quickselect: mismatch");
      $finish;
   end

endmodule
